// File: hw/rtl/pea_pkg.sv
// Package for the exchange amount pipeline: widths, constants, word types.
// No dependencies.
`default_nettype none
package pea_pkg;
	localparam int AMT_W = 63;
	localparam int PRC_W = 31;
	localparam int PROD_W = AMT_W + PRC_W;
	localparam logic [AMT_W-1:0] AMT_MAX = {AMT_W{1'b1}};
	localparam logic RULE_OLD = 1'b0;
	localparam logic RULE_NEW = 1'b1;
	localparam logic RULE_RESET = RULE_NEW;

	typedef struct packed {
		logic [AMT_W-1:0] offered_amount;
		logic [PRC_W-1:0] price_num;
		logic [PRC_W-1:0] price_den;
		logic [AMT_W-1:0] receive_limit;
		logic [AMT_W-1:0] send_limit;
	} in_word_t;

	typedef struct packed {
		logic [AMT_W-1:0] amount_received;
		logic [AMT_W-1:0] amount_sent;
		logic was_reduced;
	} out_word_t;

	// side data carried alongside one division
	typedef struct packed {
		logic mode;
		logic reduced;
		logic [AMT_W-1:0] amt;
		logic [PRC_W-1:0] num;
		logic [PRC_W-1:0] den;
		logic [AMT_W-1:0] send_limit;
	} side_t;
endpackage
`default_nettype wire

// File: hw/rtl/pea_if.sv
// Valid/ready channel interfaces for words and configuration.
// Depends on pea_pkg.
`default_nettype none
interface pea_in_if;
	logic valid;
	logic ready;
	pea_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pea_out_if;
	logic valid;
	logic ready;
	pea_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pea_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/price_exchange_amounts.sv
// Top level of the exchange amount pipeline.
// Depends on pea_pkg, pea_if, pea_muldiv, pea_clamp.
//
// Usage: words enter on in_ch (offer, price num/den, limits) and leave on
// out_ch (received, sent, reduced flag), one result per word, in order.
// cfg_ch writes rule_mode (reset 1 = new rule); write only while idle.
// Throughput: one word per cycle while out_ch does not stall. The pipeline is
// two chained dividers, each a two-stage product, 94 radix-2 stages
// (one quotient bit a stage) and a rounding register,
// plus input, clamp and output registers.
// Reset clears all valid bits; no word is in flight afterwards.
// When out_ch stalls with a word waiting, the whole pipeline holds in place;
// in_ch.ready falls then, and nothing is lost or repeated.
`default_nettype none
module price_exchange_amounts (
	input wire clk,
	input wire arst_n,
	pea_in_if.sink    in_ch,
	pea_out_if.source out_ch,
	pea_cfg_if.sink   cfg_ch
);
	import pea_pkg::*;

	logic mode_q;
	logic en;
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= RULE_RESET;
		else if (cfg_ch.valid) mode_q <= cfg_ch.data;
	end

	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	// input stage: receive-limit clamp
	logic    v_s1;
	side_t   sd_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1.mode <= mode_q;
			sd_s1.reduced <= in_ch.data.offered_amount > in_ch.data.receive_limit;
			sd_s1.amt <= (in_ch.data.offered_amount > in_ch.data.receive_limit) ?
				in_ch.data.receive_limit : in_ch.data.offered_amount;
			sd_s1.num <= in_ch.data.price_num;
			sd_s1.den <= in_ch.data.price_den;
			sd_s1.send_limit <= in_ch.data.send_limit;
		end
	end

	logic        v1;
	logic [62:0] q1;
	logic        o1;
	side_t       sd1;
	pea_muldiv u_div1 (
		.clk, .arst_n, .en, .in_valid(v_s1), .a(sd_s1.amt), .b(sd_s1.num),
		.c(sd_s1.den), .up(sd_s1.mode == RULE_NEW), .side_in(sd_s1),
		.out_valid(v1), .q(q1), .ovf(o1), .side_out(sd1)
	);

	logic        v2;
	logic [62:0] s2;
	side_t       sd2;
	pea_clamp u_clamp (
		.clk, .arst_n, .en, .in_valid(v1), .s(q1), .ovf(o1), .side_in(sd1),
		.out_valid(v2), .s_out(s2), .side_out(sd2)
	);

	side_t sd2x;
	always_comb begin
		sd2x = sd2;
		sd2x.send_limit = s2;
	end

	logic        v3;
	logic [62:0] q3;
	logic        o3;
	side_t       sd3;
	pea_muldiv u_div2 (
		.clk, .arst_n, .en, .in_valid(v2), .a(s2), .b(sd2.den), .c(sd2.num),
		.up(1'b0), .side_in(sd2x),
		.out_valid(v3), .q(q3), .ovf(o3), .side_out(sd3)
	);

	logic [62:0] recv;
	assign recv = (sd3.mode == RULE_NEW && sd3.amt < q3) ? sd3.amt : q3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ch.valid <= 1'b0;
		else if (en) out_ch.valid <= v3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.data.amount_received <= recv;
			out_ch.data.amount_sent <= sd3.send_limit;
			out_ch.data.was_reduced <= sd3.reduced;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("output word changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready == (!out_ch.valid || out_ch.ready))
		else $error("input ready does not follow output state");
	a_sent_limit: assert property (@(posedge clk) disable iff (!arst_n)
		v2 |-> s2 <= sd2.send_limit)
		else $error("sent amount beyond send limit");
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		v1 && o1 |-> q1 == AMT_MAX)
		else $error("overflow without saturation");
	a_no_cfg_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		o3 && v3 |-> q3 == AMT_MAX)
		else $error("second division overflow without saturation");
endmodule
`default_nettype wire

// File: hw/rtl/pea_muldiv.sv
// Pipelined floor/ceil(a*b/c) with 63-bit saturation, one radix-2 quotient bit
// per stage, side data travels along. Depends on pea_pkg.
`default_nettype none
module pea_muldiv (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              en,
	input  wire              in_valid,
	input  wire [62:0]       a,
	input  wire [30:0]       b,
	input  wire [30:0]       c,
	input  wire              up,
	input  wire pea_pkg::side_t side_in,
	output logic             out_valid,
	output logic [62:0]      q,
	output logic             ovf,
	output pea_pkg::side_t   side_out
);
	import pea_pkg::*;
	localparam int NS = PROD_W;
	localparam int LO_W = 32;
	localparam int PL_W = LO_W + PRC_W;
	localparam int PH_W = AMT_W - LO_W + PRC_W;

	// stage 1: partial products of the low and high halves of a
	logic              v_s1;
	logic [PL_W-1:0]   pl_s1;
	logic [PH_W-1:0]   ph_s1;
	logic [PRC_W-1:0]  c_s1;
	logic              up_s1;
	side_t             sd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= PL_W'(a[LO_W-1:0]) * PL_W'(b);
			ph_s1 <= PH_W'(a[AMT_W-1:LO_W]) * PH_W'(b);
			c_s1 <= c;
			up_s1 <= up;
			sd_s1 <= side_in;
		end
	end

	// stage 2: full product
	logic              v_s2;
	logic [PROD_W-1:0] p_s2;
	logic [PRC_W-1:0]  c_s2;
	logic              up_s2;
	side_t             sd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= PROD_W'(pl_s1) + {ph_s1, {LO_W{1'b0}}};
			c_s2 <= c_s1;
			up_s2 <= up_s1;
			sd_s2 <= sd_s1;
		end
	end

	// restoring division stages, MSB first
	logic              v_d  [NS+1];
	logic [PROD_W-1:0] qt_d [NS+1];
	logic [PRC_W:0]    r_d  [NS+1];
	logic [PRC_W-1:0]  c_d  [NS+1];
	logic              up_d [NS+1];
	side_t             sd_d [NS+1];

	assign v_d[0] = v_s2;
	assign qt_d[0] = p_s2;
	assign r_d[0] = '0;
	assign c_d[0] = c_s2;
	assign up_d[0] = up_s2;
	assign sd_d[0] = sd_s2;

	for (genvar i = 0; i < NS; i++) begin : g_div
		logic [PRC_W+1:0] t;
		logic [PRC_W+1:0] diff;
		assign t = {r_d[i], qt_d[i][PROD_W-1]};
		assign diff = t - {1'b0, 1'b0, c_d[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_d[i+1] <= 1'b0;
			else if (en) v_d[i+1] <= v_d[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[PRC_W+1]) begin
					r_d[i+1] <= diff[PRC_W:0];
					qt_d[i+1] <= {qt_d[i][PROD_W-2:0], 1'b1};
				end else begin
					r_d[i+1] <= t[PRC_W:0];
					qt_d[i+1] <= {qt_d[i][PROD_W-2:0], 1'b0};
				end
				c_d[i+1] <= c_d[i];
				up_d[i+1] <= up_d[i];
				sd_d[i+1] <= sd_d[i];
			end
		end
	end

	// final stage: round and saturate
	logic [PROD_W:0] qr;
	logic            sat;
	assign qr = {1'b0, qt_d[NS]} + {{PROD_W{1'b0}}, (up_d[NS] && r_d[NS] != '0)};
	assign sat = (c_d[NS] == '0) || (qr[PROD_W:AMT_W] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_d[NS];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			q <= sat ? AMT_MAX : qr[AMT_W-1:0];
			ovf <= sat;
			side_out <= sd_d[NS];
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/pea_clamp.sv
// Middle stage: applies the send limit and the overflow flag.
// Depends on pea_pkg.
`default_nettype none
module pea_clamp (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             en,
	input  wire             in_valid,
	input  wire [62:0]      s,
	input  wire             ovf,
	input  wire pea_pkg::side_t side_in,
	output logic            out_valid,
	output logic [62:0]     s_out,
	output pea_pkg::side_t  side_out
);
	import pea_pkg::*;
	logic over;
	side_t side_nx;
	assign over = s > side_in.send_limit;
	always_comb begin
		side_nx = side_in;
		side_nx.reduced = side_in.reduced | over |
			(ovf && side_in.mode == RULE_NEW);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			s_out <= over ? side_in.send_limit : s;
			side_out <= side_nx;
		end
	end
endmodule
`default_nettype wire
